### design/ctb_pkg.sv
// Shared types, control-byte fields and constants of the cascade timer bank.
`timescale 1ns / 1ps
`default_nettype none

package ctb_pkg;

   typedef enum logic [1:0] {
      OP_ADVANCE = 2'd0,
      OP_START   = 2'd1,
      OP_CONTROL = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_INACTIVE = 2'd0,
      MODE_PRESCALE = 2'd1,
      MODE_CASCADE  = 2'd2
   } mode_type;

   // control byte fields
   localparam int CTRL_ENABLE_BIT  = 7;
   localparam int CTRL_IRQ_BIT     = 6;
   localparam int CTRL_CASCADE_BIT = 2;

   localparam logic [16:0]        FULL_RELOAD = 17'h10000;
   localparam logic [26:0]        NO_EVENT    = 27'd67108864;
   localparam logic signed [27:0] REM_MIN     = -28'sd134217728;
   localparam logic signed [28:0] REM_FLOOR   = -29'sd134217728;

   typedef struct packed {
      logic        fire;
      op_type      op;
      logic [15:0] value;
      logic [26:0] cycles;
   } cmd_type;

   typedef struct packed {
      logic        expired;
      logic        irq;
      logic        prescaled;
      logic [26:0] due;
      logic [15:0] readback;
   } status_type;

   // prescale code to shift: divide by 1, 64, 256 or 1024
   function automatic logic [3:0] shift_of(input logic [1:0] code);
      logic [3:0] s;
      case (code)
         2'd0:    s = 4'd0;
         2'd1:    s = 4'd6;
         2'd2:    s = 4'd8;
         2'd3:    s = 4'd10;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

### design/cascade_timer_bank_core.sv
// Top level of the cascade timer bank: request register, timer slices, response register.
`timescale 1ns / 1ps
`default_nettype none

// Bank of NUM_TIMERS 16-bit timers, prescaled or cascaded.
// Request channel (req_valid/req_ready): req_op selects advance time, set start
// value or write control; req_timer_sel names the timer written or read back;
// req_value carries the start value or control byte; req_cycles the elapsed
// cycles of an advance.
// Response channel (rsp_valid/rsp_ready): one response per request with the
// expiry and IRQ flags of that request, the readback of the selected timer
// after it, and the cycles to the earliest prescaled expiry.
// A request accepted into the request register moves into the response register
// once that register is free or draining, and is then presented as a response.
// Throughput: one request per cycle while rsp_ready stays high; the timer update,
// cascade chain and minimum search all sit between the request register and the
// response register, so the timer state is ready for the following request at once.
// Stall: while rsp_ready is low the response holds, one further request waits
// in the request register, and req_ready drops until the response moves.
// Reset: every timer goes inactive with a full reload of 65536 ticks, zero
// count and zero readback; both registers empty.

module cascade_timer_bank_core #(
   parameter int NUM_TIMERS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [1:0]  req_timer_sel,
   input  wire logic [15:0] req_value,
   input  wire logic [26:0] req_cycles,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [3:0]  rsp_irq_flags,
   output      logic [3:0]  rsp_overflow_flags,
   output      logic [15:0] rsp_counter_value,
   output      logic [26:0] rsp_next_event
);

   // only the first four timers report flags
   localparam int FLAG_BITS = (NUM_TIMERS < 4) ? NUM_TIMERS : 4;

   // request register
   logic               req_full_ff, req_full_in;
   ctb_pkg::op_type    op_ff;
   logic [1:0]         sel_ff;
   logic [15:0]        value_ff;
   logic [26:0]        cycles_ff;

   // response register
   logic               rsp_full_ff, rsp_full_in;
   logic [3:0]         irq_ff, irq_in;
   logic [3:0]         ovf_ff, ovf_in;
   logic [15:0]        counter_ff, counter_in;
   logic [26:0]        event_ff;
   logic [26:0]        event_in;

   logic               req_take;
   logic               fire;
   ctb_pkg::cmd_type   cmd;
   logic [NUM_TIMERS-1:0] hit;
   ctb_pkg::status_type status [NUM_TIMERS];

   // advance the held request when the response register is free or draining
   assign fire      = req_full_ff && (!rsp_full_ff || rsp_ready);
   assign req_ready = !req_full_ff || fire;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      cmd.fire   = fire;
      cmd.op     = op_ff;
      cmd.value  = value_ff;
      cmd.cycles = cycles_ff;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         hit[t] = (int'(sel_ff) == t);
      end
   end

   // timer slices; each cascaded timer is clocked by the expiry of the one before
   for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
      if (t == 0) begin : g_first
         ctb_timer_slice u_slice (
            .clock   (clock),
            .reset   (reset),
            .cmd     (cmd),
            .hit     (hit[t]),
            .casc_in (1'b0),
            .status  (status[t])
         );
      end else begin : g_chain
         ctb_timer_slice u_slice (
            .clock   (clock),
            .reset   (reset),
            .cmd     (cmd),
            .hit     (hit[t]),
            .casc_in (status[t-1].expired),
            .status  (status[t])
         );
      end
   end

   ctb_event_min #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_event_min (
      .status     (status),
      .next_event (event_in)
   );

   // collect flags and readback for the response
   always_comb begin
      irq_in     = 4'd0;
      ovf_in     = 4'd0;
      counter_in = 16'd0;
      for (int b = 0; b < FLAG_BITS; b++) begin
         irq_in[b] = status[b].irq;
         ovf_in[b] = status[b].expired;
      end
      for (int t = 0; t < NUM_TIMERS; t++) begin
         if (hit[t]) begin
            counter_in = status[t].readback;
         end
      end
   end

   always_comb begin
      if (req_take) begin
         req_full_in = 1'b1;
      end else if (fire) begin
         req_full_in = 1'b0;
      end else begin
         req_full_in = req_full_ff;
      end

      if (fire) begin
         rsp_full_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_full_in = 1'b0;
      end else begin
         rsp_full_in = rsp_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
         rsp_full_ff <= 1'b0;
      end else begin
         req_full_ff <= req_full_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   // hold payloads; load the request on a handshake and the response when it fires
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff     <= ctb_pkg::op_type'(req_op);
         sel_ff    <= req_timer_sel;
         value_ff  <= req_value;
         cycles_ff <= req_cycles;
      end
      if (fire) begin
         irq_ff     <= irq_in;
         ovf_ff     <= ovf_in;
         counter_ff <= counter_in;
         event_ff   <= event_in;
      end
   end

   assign rsp_valid          = rsp_full_ff;
   assign rsp_irq_flags      = irq_ff;
   assign rsp_overflow_flags = ovf_ff;
   assign rsp_counter_value  = counter_ff;
   assign rsp_next_event     = event_ff;

endmodule

`default_nettype wire

### design/ctb_timer_slice.sv
// One timer: its state registers and the next-state logic for a request.
`timescale 1ns / 1ps
`default_nettype none

module ctb_timer_slice (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctb_pkg::cmd_type     cmd,
   input  wire logic                 hit,
   input  wire logic                 casc_in,
   output      ctb_pkg::status_type  status
);

   ctb_pkg::mode_type  mode_ff, mode_in;
   logic signed [27:0] rem_ff, rem_in;
   logic [16:0]        reload_ff, reload_in;
   logic [3:0]         shift_ff, shift_in;
   logic               irq_ff, irq_in;
   logic [15:0]        readback_ff, readback_in;

   logic               active;
   logic               expired;
   logic signed [28:0] rem_ext;
   logic signed [28:0] sub_val;
   logic signed [28:0] sum_val;
   logic [26:0]        reload_amt;
   logic signed [27:0] sat_val;
   logic signed [27:0] quot;
   logic [27:0]        neg_quot;
   logic [3:0]         new_shift;
   logic [26:0]        enable_amt;
   logic [16:0]        start_rb;

   always_comb begin
      active     = (mode_ff == ctb_pkg::MODE_PRESCALE) || (mode_ff == ctb_pkg::MODE_CASCADE);
      rem_ext    = {rem_ff[27], rem_ff};
      reload_amt = 27'(reload_ff) << shift_ff;

      // cascaded timers take one count from the timer before, prescaled ones take cycles
      if (mode_ff == ctb_pkg::MODE_CASCADE) begin
         sub_val = casc_in ? (rem_ext - 29'sd1) : rem_ext;
      end else begin
         sub_val = rem_ext - $signed({2'b00, cmd.cycles});
      end

      expired = (cmd.op == ctb_pkg::OP_ADVANCE) && active && (sub_val <= 29'sd0);
      sum_val = expired ? (sub_val + $signed({2'b00, reload_amt})) : sub_val;
      sat_val = (sum_val < ctb_pkg::REM_FLOOR) ? ctb_pkg::REM_MIN : sum_val[27:0];

      quot     = sat_val >>> shift_ff;
      neg_quot = 28'd0 - quot;

      new_shift  = cmd.value[ctb_pkg::CTRL_CASCADE_BIT] ? 4'd0
                                                         : ctb_pkg::shift_of(cmd.value[1:0]);
      enable_amt = 27'(reload_ff) << new_shift;
      start_rb   = ctb_pkg::FULL_RELOAD - reload_ff;

      mode_in     = mode_ff;
      rem_in      = rem_ff;
      reload_in   = reload_ff;
      shift_in    = shift_ff;
      irq_in      = irq_ff;
      readback_in = readback_ff;

      case (cmd.op)
         ctb_pkg::OP_ADVANCE: begin
            if (active) begin
               rem_in      = sat_val;
               readback_in = neg_quot[15:0];
            end
         end
         ctb_pkg::OP_START: begin
            if (hit) begin
               reload_in = ctb_pkg::FULL_RELOAD - {1'b0, cmd.value};
            end
         end
         ctb_pkg::OP_CONTROL: begin
            if (hit) begin
               if (!cmd.value[ctb_pkg::CTRL_ENABLE_BIT]) begin
                  mode_in = ctb_pkg::MODE_INACTIVE;
               end else if (!active) begin
                  mode_in     = cmd.value[ctb_pkg::CTRL_CASCADE_BIT] ? ctb_pkg::MODE_CASCADE
                                                                     : ctb_pkg::MODE_PRESCALE;
                  shift_in    = new_shift;
                  irq_in      = cmd.value[ctb_pkg::CTRL_IRQ_BIT];
                  readback_in = start_rb[15:0];
                  rem_in      = $signed({1'b0, enable_amt});
               end
            end
         end
         default: begin
         end
      endcase

      status.expired   = expired;
      status.irq       = expired && irq_ff;
      status.prescaled = (mode_in == ctb_pkg::MODE_PRESCALE);
      status.due       = rem_in[27] ? 27'd0 : rem_in[26:0];
      status.readback  = readback_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ctb_pkg::MODE_INACTIVE;
         rem_ff      <= 28'sd0;
         reload_ff   <= ctb_pkg::FULL_RELOAD;
         shift_ff    <= 4'd0;
         irq_ff      <= 1'b0;
         readback_ff <= 16'd0;
      end else if (cmd.fire) begin
         mode_ff     <= mode_in;
         rem_ff      <= rem_in;
         reload_ff   <= reload_in;
         shift_ff    <= shift_in;
         irq_ff      <= irq_in;
         readback_ff <= readback_in;
      end
   end

endmodule

`default_nettype wire

### design/ctb_event_min.sv
// Earliest prescaled expiry over the bank after a request.
`timescale 1ns / 1ps
`default_nettype none

module ctb_event_min #(
   parameter int NUM_TIMERS = 4
) (
   input  wire ctb_pkg::status_type status [NUM_TIMERS],
   output      logic [26:0]         next_event
);

   always_comb begin
      next_event = ctb_pkg::NO_EVENT;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         if (status[t].prescaled && (status[t].due < next_event)) begin
            next_event = status[t].due;
         end
      end
   end

endmodule

`default_nettype wire
